@@ rtl/core/mvc_pkg.sv @@
// Package for the multichannel valid convolution block.
// Holds the default sizes, operation and register codes, and the control/status structs.
// No dependencies.
package mvc_pkg;

    localparam int DEF_MAX_IMAGE_DIM  = 32;
    localparam int DEF_MAX_CHANNELS   = 4;
    localparam int DEF_MAX_KERNEL_DIM = 5;

    localparam int OP_W    = 2;
    localparam int ADDR_W  = 12;
    localparam int DATA_W  = 16;
    localparam int POS_W   = 5;
    localparam int SUM_W   = 40;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 6;
    localparam int IMG_REG_W = 6;
    localparam int KER_REG_W = 3;
    localparam int CHK_W   = 7;

    localparam logic [OP_W-1:0] OP_WR_PIXEL  = 2'd0;
    localparam logic [OP_W-1:0] OP_WR_WEIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_COMPUTE   = 2'd2;

    localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 3'd2;
    localparam logic [IDX_W-1:0] REG_KERNEL_WIDTH  = 3'd3;
    localparam logic [IDX_W-1:0] REG_KERNEL_HEIGHT = 3'd4;

    localparam logic [IMG_REG_W-1:0] RST_IMAGE_WIDTH   = 6'd32;
    localparam logic [IMG_REG_W-1:0] RST_IMAGE_HEIGHT  = 6'd32;
    localparam logic [KER_REG_W-1:0] RST_CHANNEL_COUNT = 3'd1;
    localparam logic [KER_REG_W-1:0] RST_KERNEL_WIDTH  = 3'd3;
    localparam logic [KER_REG_W-1:0] RST_KERNEL_HEIGHT = 3'd3;

    typedef struct packed {
        logic accept;
        logic setup;
        logic issue;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic last;
        logic busy;
        logic out_free;
    } stat_t;

endpackage

@@ rtl/core/mvc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module mvc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/mvc_ctrl.sv @@
// Controller state machine for the convolution block.
// Depends on mvc_pkg for the command and status structs and operation codes.
module mvc_ctrl (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic [mvc_pkg::OP_W-1:0]  operation,
    output logic                      in_ready,
    input  mvc_pkg::stat_t            stat,
    output mvc_pkg::cmd_t             cmd
);
    import mvc_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_RUN   = 5'b00100,
        S_DRAIN = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        cmd.accept   = 1'b0;
        cmd.setup    = 1'b0;
        cmd.issue    = 1'b0;
        cmd.load_out = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
                if (in_valid && operation == OP_COMPUTE)
                begin
                    state_next = S_SETUP;
                end
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = stat.bad ? S_DONE : S_RUN;
            end
            S_RUN:
            begin
                cmd.issue = 1'b1;
                if (stat.last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (!stat.busy)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/mvc_datapath.sv @@
// Datapath: configuration registers, address counters, multiply-accumulate and output register.
// Depends on mvc_pkg; drives the read and write ports of both stores.
module mvc_datapath #(
    parameter int MAX_IMAGE_DIM  = mvc_pkg::DEF_MAX_IMAGE_DIM,
    parameter int MAX_CHANNELS   = mvc_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_KERNEL_DIM = mvc_pkg::DEF_MAX_KERNEL_DIM,
    parameter int PA_W           = 12,
    parameter int WA_W           = 7
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [mvc_pkg::IDX_W-1:0]        cfg_index,
    input  logic [mvc_pkg::CFG_W-1:0]        cfg_data,
    input  logic [mvc_pkg::OP_W-1:0]         operation,
    input  logic [mvc_pkg::ADDR_W-1:0]       address,
    input  logic signed [mvc_pkg::DATA_W-1:0] value,
    input  logic [mvc_pkg::POS_W-1:0]        out_row,
    input  logic [mvc_pkg::POS_W-1:0]        out_col,
    input  mvc_pkg::cmd_t                    cmd,
    output mvc_pkg::stat_t                   stat,
    output logic                             pix_we,
    output logic [PA_W-1:0]                  pix_waddr,
    output logic [PA_W-1:0]                  pix_raddr,
    input  logic [mvc_pkg::DATA_W-1:0]       pix_rdata,
    output logic                             wgt_we,
    output logic [WA_W-1:0]                  wgt_waddr,
    output logic [WA_W-1:0]                  wgt_raddr,
    input  logic [mvc_pkg::DATA_W-1:0]       wgt_rdata,
    output logic [mvc_pkg::DATA_W-1:0]       wdata,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic signed [mvc_pkg::SUM_W-1:0] sum,
    output logic                             status
);
    import mvc_pkg::*;

    localparam int PIX_DEPTH = MAX_CHANNELS * MAX_IMAGE_DIM * MAX_IMAGE_DIM;
    localparam int WGT_DEPTH = MAX_CHANNELS * MAX_KERNEL_DIM * MAX_KERNEL_DIM;
    localparam int ID_W = $clog2(MAX_IMAGE_DIM + 1);
    localparam int KD_W = $clog2(MAX_KERNEL_DIM + 1);
    localparam int CH_W = $clog2(MAX_CHANNELS + 1);
    localparam int PR_W = POS_W + ID_W;
    localparam int PL_W = 2 * ID_W;

    logic [IMG_REG_W-1:0] image_width_reg;
    logic [IMG_REG_W-1:0] image_height_reg;
    logic [KER_REG_W-1:0] channel_count_reg;
    logic [KER_REG_W-1:0] kernel_width_reg;
    logic [KER_REG_W-1:0] kernel_height_reg;

    logic [ID_W-1:0] iw;
    logic [ID_W-1:0] ih;
    logic [CH_W-1:0] nc;
    logic [KD_W-1:0] kw;
    logic [KD_W-1:0] kh;

    logic [POS_W-1:0] row_reg;
    logic [POS_W-1:0] col_reg;
    logic [PR_W-1:0]  row_prod;
    logic [PL_W-1:0]  plane_prod;
    logic [PA_W-1:0]  start_calc;
    logic             bad;

    logic [PA_W-1:0] pa_reg;
    logic [PA_W-1:0] row_start_reg;
    logic [PA_W-1:0] chan_start_reg;
    logic [PA_W-1:0] plane_reg;
    logic [WA_W-1:0] wa_reg;
    logic [KD_W-1:0] kx_reg;
    logic [KD_W-1:0] ky_reg;
    logic [CH_W-1:0] c_reg;
    logic            bad_reg;
    logic            kx_end;
    logic            ky_end;
    logic            c_end;

    logic                     v1_reg;
    logic                     v2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [SUM_W-1:0]  acc_reg;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic signed [SUM_W-1:0] sum_reg;
    logic                    status_reg;

    // Clamp registers to their usable range on use
    always_comb
    begin
        if (image_width_reg == '0)
            iw = ID_W'(1);
        else if (32'(image_width_reg) > MAX_IMAGE_DIM)
            iw = ID_W'(MAX_IMAGE_DIM);
        else
            iw = ID_W'(image_width_reg);

        if (image_height_reg == '0)
            ih = ID_W'(1);
        else if (32'(image_height_reg) > MAX_IMAGE_DIM)
            ih = ID_W'(MAX_IMAGE_DIM);
        else
            ih = ID_W'(image_height_reg);

        if (channel_count_reg == '0)
            nc = CH_W'(1);
        else if (32'(channel_count_reg) > MAX_CHANNELS)
            nc = CH_W'(MAX_CHANNELS);
        else
            nc = CH_W'(channel_count_reg);

        if (kernel_width_reg == '0)
            kw = KD_W'(1);
        else if (32'(kernel_width_reg) > MAX_KERNEL_DIM)
            kw = KD_W'(MAX_KERNEL_DIM);
        else
            kw = KD_W'(kernel_width_reg);

        if (kernel_height_reg == '0)
            kh = KD_W'(1);
        else if (32'(kernel_height_reg) > MAX_KERNEL_DIM)
            kh = KD_W'(MAX_KERNEL_DIM);
        else
            kh = KD_W'(kernel_height_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg   <= RST_IMAGE_WIDTH;
            image_height_reg  <= RST_IMAGE_HEIGHT;
            channel_count_reg <= RST_CHANNEL_COUNT;
            kernel_width_reg  <= RST_KERNEL_WIDTH;
            kernel_height_reg <= RST_KERNEL_HEIGHT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data;
                REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data;
                REG_CHANNEL_COUNT: channel_count_reg <= cfg_data[KER_REG_W-1:0];
                REG_KERNEL_WIDTH:  kernel_width_reg  <= cfg_data[KER_REG_W-1:0];
                REG_KERNEL_HEIGHT: kernel_height_reg <= cfg_data[KER_REG_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Store writes
    assign wdata     = value;
    assign pix_waddr = PA_W'(address);
    assign wgt_waddr = WA_W'(address);
    assign pix_we    = cmd.accept && operation == OP_WR_PIXEL
                       && 32'(address) < PIX_DEPTH;
    assign wgt_we    = cmd.accept && operation == OP_WR_WEIGHT
                       && 32'(address) < WGT_DEPTH;

    // Position setup
    assign row_prod   = PR_W'(row_reg) * PR_W'(iw);
    assign plane_prod = PL_W'(iw) * PL_W'(ih);
    assign start_calc = PA_W'(row_prod) + PA_W'(col_reg);
    assign bad        = (CHK_W'(row_reg) + CHK_W'(kh) > CHK_W'(ih))
                        || (CHK_W'(col_reg) + CHK_W'(kw) > CHK_W'(iw));

    assign kx_end = kx_reg == KD_W'(kw - KD_W'(1));
    assign ky_end = ky_reg == KD_W'(kh - KD_W'(1));
    assign c_end  = c_reg == CH_W'(nc - CH_W'(1));

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            row_reg <= out_row;
            col_reg <= out_col;
        end
        if (cmd.setup)
        begin
            pa_reg         <= start_calc;
            row_start_reg  <= start_calc;
            chan_start_reg <= start_calc;
            plane_reg      <= PA_W'(plane_prod);
            wa_reg         <= '0;
            kx_reg         <= '0;
            ky_reg         <= '0;
            c_reg          <= '0;
            bad_reg        <= bad;
        end
        else if (cmd.issue)
        begin
            wa_reg <= wa_reg + WA_W'(1);
            if (!kx_end)
            begin
                kx_reg <= kx_reg + KD_W'(1);
                pa_reg <= pa_reg + PA_W'(1);
            end
            else if (!ky_end)
            begin
                kx_reg        <= '0;
                ky_reg        <= ky_reg + KD_W'(1);
                row_start_reg <= row_start_reg + PA_W'(iw);
                pa_reg        <= row_start_reg + PA_W'(iw);
            end
            else
            begin
                kx_reg         <= '0;
                ky_reg         <= '0;
                c_reg          <= c_reg + CH_W'(1);
                chan_start_reg <= chan_start_reg + plane_reg;
                row_start_reg  <= chan_start_reg + plane_reg;
                pa_reg         <= chan_start_reg + plane_reg;
            end
        end
    end

    assign pix_raddr = pa_reg;
    assign wgt_raddr = wa_reg;

    // Multiply-accumulate pipeline
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg)
        begin
            prod_reg <= $signed(pix_rdata) * $signed(wgt_rdata);
        end
        if (cmd.setup)
        begin
            acc_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(prod_reg);
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            sum_reg    <= bad_reg ? '0 : acc_reg;
            status_reg <= bad_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sum       = sum_reg;
    assign status    = status_reg;

    assign stat.bad      = bad;
    assign stat.last     = kx_end && ky_end && c_end;
    assign stat.busy     = v1_reg || v2_reg;
    assign stat.out_free = !out_valid_reg || out_ready;

endmodule

@@ rtl/core/multichannel_valid_convolution.sv @@
// Compute item: states setup, run, drain, done; run issues one of the N kernel elements per
// cycle, N = channels*kernel rows*kernel columns. Done loads the result once the output
// register is free; the next transaction is taken only after that. Out-of-area position:
// setup goes straight to done, result zero with status set. One multiply-accumulate unit
// fed by one read port per store takes one kernel element per cycle. Reset: configuration
// registers return to their defaults, output empty; store contents stay undefined until
// written. Top level; depends on mvc_pkg, mvc_ctrl, mvc_datapath and mvc_ram.
module multichannel_valid_convolution #(
    parameter int MAX_IMAGE_DIM  = mvc_pkg::DEF_MAX_IMAGE_DIM,
    parameter int MAX_CHANNELS   = mvc_pkg::DEF_MAX_CHANNELS,
    parameter int MAX_KERNEL_DIM = mvc_pkg::DEF_MAX_KERNEL_DIM
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [mvc_pkg::IDX_W-1:0]         cfg_index,
    input  logic [mvc_pkg::CFG_W-1:0]         cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [mvc_pkg::OP_W-1:0]          operation,
    input  logic [mvc_pkg::ADDR_W-1:0]        address,
    input  logic signed [mvc_pkg::DATA_W-1:0] value,
    input  logic [mvc_pkg::POS_W-1:0]         out_row,
    input  logic [mvc_pkg::POS_W-1:0]         out_col,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [mvc_pkg::SUM_W-1:0]  sum,
    output logic                              status
);
    import mvc_pkg::*;

    localparam int PIX_DEPTH = MAX_CHANNELS * MAX_IMAGE_DIM * MAX_IMAGE_DIM;
    localparam int WGT_DEPTH = MAX_CHANNELS * MAX_KERNEL_DIM * MAX_KERNEL_DIM;
    localparam int PA_W = (PIX_DEPTH > 1) ? $clog2(PIX_DEPTH) : 1;
    localparam int WA_W = (WGT_DEPTH > 1) ? $clog2(WGT_DEPTH) : 1;

    cmd_t  cmd;
    stat_t stat;

    logic              pix_we;
    logic [PA_W-1:0]   pix_waddr;
    logic [PA_W-1:0]   pix_raddr;
    logic [DATA_W-1:0] pix_rdata;
    logic              wgt_we;
    logic [WA_W-1:0]   wgt_waddr;
    logic [WA_W-1:0]   wgt_raddr;
    logic [DATA_W-1:0] wgt_rdata;
    logic [DATA_W-1:0] wdata;

    mvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .operation (operation),
        .in_ready  (in_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mvc_datapath #(
        .MAX_IMAGE_DIM  (MAX_IMAGE_DIM),
        .MAX_CHANNELS   (MAX_CHANNELS),
        .MAX_KERNEL_DIM (MAX_KERNEL_DIM),
        .PA_W           (PA_W),
        .WA_W           (WA_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .operation (operation),
        .address   (address),
        .value     (value),
        .out_row   (out_row),
        .out_col   (out_col),
        .cmd       (cmd),
        .stat      (stat),
        .pix_we    (pix_we),
        .pix_waddr (pix_waddr),
        .pix_raddr (pix_raddr),
        .pix_rdata (pix_rdata),
        .wgt_we    (wgt_we),
        .wgt_waddr (wgt_waddr),
        .wgt_raddr (wgt_raddr),
        .wgt_rdata (wgt_rdata),
        .wdata     (wdata),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .sum       (sum),
        .status    (status)
    );

    mvc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (PIX_DEPTH),
        .AW    (PA_W)
    ) u_pixel_ram (
        .clk   (clk),
        .we    (pix_we),
        .waddr (pix_waddr),
        .wdata (wdata),
        .raddr (pix_raddr),
        .rdata (pix_rdata)
    );

    mvc_ram #(
        .WIDTH (DATA_W),
        .DEPTH (WGT_DEPTH),
        .AW    (WA_W)
    ) u_weight_ram (
        .clk   (clk),
        .we    (wgt_we),
        .waddr (wgt_waddr),
        .wdata (wdata),
        .raddr (wgt_raddr),
        .rdata (wgt_rdata)
    );

endmodule
